FILE: design/mpqa_pkg.sv
// ----------------------------------------------------------------------------
// mpqa_pkg: shared definitions for the maximum-priority queue
// Sizes, operation and status codes, and the types that pass between the
// controller and the row of storage cells.
// ----------------------------------------------------------------------------
package mpqa_pkg;

  // Number of entries the queue can hold (2 to 15).
  localparam int CAPACITY = 8;
  // Bits needed to address one cell, and to count from zero up to CAPACITY.
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int KEY_W    = 8;
  localparam int TAG_W    = 32;
  localparam int OCC_W    = 4;

  // Operation codes carried on the func field.
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  typedef enum logic [1:0] {
    STAT_ENQUEUED = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_DEQUEUED = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // One stored entry.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] name;
    logic [TAG_W-1:0] ident;
  } entry_t;

  // Running maximum as it travels along the row of cells.
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
    entry_t           ent;
  } best_t;

  // Per-cell control from the controller.
  typedef struct packed {
    logic occupied;
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

FILE: design/max_priority_queue_array.sv
// ----------------------------------------------------------------------------
// max_priority_queue_array: bounded maximum-priority queue in a cell row
// An item either enqueues a key with two tags or dequeues the largest key.
//
// Input channel (in_valid / in_stall): in_func selects enqueue or dequeue;
// the key and tags are ignored on a dequeue. One item is taken at a time, and
// in_stall stays high from acceptance until its result is committed.
// Result channel (out_valid / out_stall): one result item per input item,
// giving status, the dequeued entry (zero unless dequeued) and occupancy.
// The result sits in an output register, so the next item is accepted while
// an earlier result still waits to be taken.
// Sequence: an enqueue, a full enqueue or an empty dequeue goes from IDLE
// straight to FINISH. A dequeue first waits in SCAN while the running
// maximum travels one cell per cycle along the row to its last cell.
// When the receiver stalls, the result holds and the next item completes its
// work but waits in its final state until the output register frees.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result; entry contents are left as they were and are never read empty.
// ----------------------------------------------------------------------------
module max_priority_queue_array (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_func,
  input  logic [mpqa_pkg::KEY_W-1:0] in_entry_key,
  input  logic [mpqa_pkg::TAG_W-1:0] in_name_tag,
  input  logic [mpqa_pkg::TAG_W-1:0] in_ident_tag,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_status,
  output logic [mpqa_pkg::KEY_W-1:0] out_key,
  output logic [mpqa_pkg::TAG_W-1:0] out_name_tag,
  output logic [mpqa_pkg::TAG_W-1:0] out_ident_tag,
  output logic [mpqa_pkg::OCC_W-1:0] out_occupancy
);

  // Cell i holds the entry inserted i-th among those still stored, so the
  // row is always in insertion order and a tie goes to the lower index.
  mpqa_pkg::entry_t                             ent    [mpqa_pkg::CAPACITY];
  mpqa_pkg::best_t                              best   [mpqa_pkg::CAPACITY];
  mpqa_pkg::cell_ctrl_t [mpqa_pkg::CAPACITY-1:0] cell_ctrl;
  mpqa_pkg::entry_t                             load_ent;

  mpqa_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_entry_key  (in_entry_key),
    .in_name_tag   (in_name_tag),
    .in_ident_tag  (in_ident_tag),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_key       (out_key),
    .out_name_tag  (out_name_tag),
    .out_ident_tag (out_ident_tag),
    .out_occupancy (out_occupancy),
    .best_i        (best[mpqa_pkg::CAPACITY-1]),
    .cell_ctrl_o   (cell_ctrl),
    .load_ent_o    (load_ent)
  );

  // The running maximum enters at cell 0 with nothing found and leaves at
  // the last cell. On a dequeue every cell at or above the winner takes its
  // right neighbour's entry, closing the gap; the last cell
  // takes an empty entry, which is never read because it is now unoccupied.
  for (genvar i = 0; i < mpqa_pkg::CAPACITY; i++) begin : g_cell
    mpqa_pkg::entry_t right_ent;
    mpqa_pkg::best_t  best_in;

    if (i == mpqa_pkg::CAPACITY - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_mid
      assign right_ent = ent[i+1];
    end

    if (i == 0) begin : g_first
      assign best_in = '0;
    end else begin : g_rest
      assign best_in = best[i-1];
    end

    mpqa_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (mpqa_pkg::IDX_W'(i)),
      .ctrl      (cell_ctrl[i]),
      .load_ent  (load_ent),
      .right_ent (right_ent),
      .ent_o     (ent[i]),
      .best_i    (best_in),
      .best_o    (best[i])
    );
  end

endmodule

FILE: design/mpqa_cell.sv
// ----------------------------------------------------------------------------
// mpqa_cell: one storage slot of the priority queue
// Holds one entry, loads a new one or takes its right neighbour's on a
// dequeue, and passes the running maximum on to the next cell.
// ----------------------------------------------------------------------------
module mpqa_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [mpqa_pkg::IDX_W-1:0] cell_idx,
  input  mpqa_pkg::cell_ctrl_t      ctrl,
  input  mpqa_pkg::entry_t          load_ent,
  input  mpqa_pkg::entry_t          right_ent,
  output mpqa_pkg::entry_t          ent_o,
  input  mpqa_pkg::best_t           best_i,
  output mpqa_pkg::best_t           best_o
);

  mpqa_pkg::entry_t ent_r;
  mpqa_pkg::best_t  best_r;
  mpqa_pkg::best_t  best_nxt;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      ent_r <= load_ent;
    end else if (ctrl.shift) begin
      ent_r <= right_ent;
    end
  end

  // Strictly greater keeps the earlier entry on a tie.
  always_comb begin
    best_nxt = best_i;
    if (ctrl.occupied && (!best_i.found || (ent_r.key > best_i.ent.key))) begin
      best_nxt.found = 1'b1;
      best_nxt.idx   = cell_idx;
      best_nxt.ent   = ent_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r.found <= 1'b0;
    end else begin
      best_r <= best_nxt;
    end
  end

  assign ent_o  = ent_r;
  assign best_o = best_r;

endmodule

FILE: design/mpqa_ctrl.sv
// ----------------------------------------------------------------------------
// mpqa_ctrl: sequencer and output register of the priority queue
// Takes one item at a time, waits for the maximum to settle along the cell
// row on a dequeue, updates the fill count and cells, and holds the result.
// ----------------------------------------------------------------------------
module mpqa_ctrl (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    in_func,
  input  logic [mpqa_pkg::KEY_W-1:0]              in_entry_key,
  input  logic [mpqa_pkg::TAG_W-1:0]              in_name_tag,
  input  logic [mpqa_pkg::TAG_W-1:0]              in_ident_tag,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [1:0]                              out_status,
  output logic [mpqa_pkg::KEY_W-1:0]              out_key,
  output logic [mpqa_pkg::TAG_W-1:0]              out_name_tag,
  output logic [mpqa_pkg::TAG_W-1:0]              out_ident_tag,
  output logic [mpqa_pkg::OCC_W-1:0]              out_occupancy,
  input  mpqa_pkg::best_t                         best_i,
  output mpqa_pkg::cell_ctrl_t [mpqa_pkg::CAPACITY-1:0] cell_ctrl_o,
  output mpqa_pkg::entry_t                        load_ent_o
);

  mpqa_pkg::state_t                state_r, state_nxt;
  logic [mpqa_pkg::IDX_W-1:0]      cnt_r, cnt_nxt;
  logic [mpqa_pkg::CNT_W-1:0]      fill_r, fill_nxt;
  logic                            out_valid_r;
  logic                            op_r;
  mpqa_pkg::entry_t                ent_r;
  mpqa_pkg::status_t               status_r, status_nxt;
  logic [mpqa_pkg::KEY_W-1:0]      key_r, key_nxt;
  logic [mpqa_pkg::TAG_W-1:0]      name_r, name_nxt;
  logic [mpqa_pkg::TAG_W-1:0]      ident_r, ident_nxt;
  logic [mpqa_pkg::OCC_W-1:0]      occ_r;
  logic                            out_free;
  logic                            commit;
  logic                            enq_ok;
  logic                            deq_ok;

  assign in_stall = (state_r != mpqa_pkg::ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mpqa_pkg::ST_IDLE: begin
        if (in_valid) begin
          if ((in_func == mpqa_pkg::FUNC_DEQ) && (fill_r != '0)) begin
            state_nxt = mpqa_pkg::ST_SCAN;
          end else begin
            state_nxt = mpqa_pkg::ST_FINISH;
          end
        end
      end
      mpqa_pkg::ST_SCAN: begin
        if (cnt_r == mpqa_pkg::IDX_W'(mpqa_pkg::CAPACITY - 1)) begin
          state_nxt = mpqa_pkg::ST_FINISH;
        end
      end
      mpqa_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = mpqa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mpqa_pkg::ST_IDLE;
    endcase
  end

  // Outputs: result, fill count update and cell control.
  always_comb begin
    commit     = (state_r == mpqa_pkg::ST_FINISH) && out_free;
    cnt_nxt    = (state_r == mpqa_pkg::ST_SCAN) ? cnt_r + 1'b1 : '0;
    fill_nxt   = fill_r;
    status_nxt = mpqa_pkg::STAT_ENQUEUED;
    key_nxt    = '0;
    name_nxt   = '0;
    ident_nxt  = '0;
    enq_ok     = 1'b0;
    deq_ok     = 1'b0;
    if (op_r == mpqa_pkg::FUNC_ENQ) begin
      if (fill_r == mpqa_pkg::CNT_W'(mpqa_pkg::CAPACITY)) begin
        status_nxt = mpqa_pkg::STAT_FULL;
      end else begin
        status_nxt = mpqa_pkg::STAT_ENQUEUED;
        enq_ok     = commit;
        fill_nxt   = fill_r + 1'b1;
      end
    end else begin
      if (fill_r == '0) begin
        status_nxt = mpqa_pkg::STAT_EMPTY;
      end else begin
        status_nxt = mpqa_pkg::STAT_DEQUEUED;
        key_nxt    = best_i.ent.key;
        name_nxt   = best_i.ent.name;
        ident_nxt  = best_i.ent.ident;
        deq_ok     = commit;
        fill_nxt   = fill_r - 1'b1;
      end
    end
    for (int i = 0; i < mpqa_pkg::CAPACITY; i++) begin
      cell_ctrl_o[i].occupied = (mpqa_pkg::CNT_W'(i) < fill_r);
      cell_ctrl_o[i].load     = enq_ok &&
                                (fill_r[mpqa_pkg::IDX_W-1:0] == mpqa_pkg::IDX_W'(i));
      cell_ctrl_o[i].shift    = deq_ok && (mpqa_pkg::IDX_W'(i) >= best_i.idx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mpqa_pkg::ST_IDLE;
      cnt_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= commit || (out_valid_r && out_stall);
      if (commit) begin
        fill_r <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == mpqa_pkg::ST_IDLE) && in_valid) begin
      op_r      <= in_func;
      ent_r.key   <= in_entry_key;
      ent_r.name  <= in_name_tag;
      ent_r.ident <= in_ident_tag;
    end
    if (commit) begin
      status_r <= status_nxt;
      key_r    <= key_nxt;
      name_r   <= name_nxt;
      ident_r  <= ident_nxt;
      occ_r    <= mpqa_pkg::OCC_W'(fill_nxt);
    end
  end

  assign load_ent_o    = ent_r;
  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_key       = key_r;
  assign out_name_tag  = name_r;
  assign out_ident_tag = ident_r;
  assign out_occupancy = occ_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= mpqa_pkg::CNT_W'(mpqa_pkg::CAPACITY))
    else $error("fill count above capacity");

  a_deq_found: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && (op_r == mpqa_pkg::FUNC_DEQ) && (fill_r != '0)) |-> best_i.found)
    else $error("dequeue committed without a maximum from the cell row");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("committed result not presented");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == mpqa_pkg::STAT_EMPTY)) |-> (occ_r == '0))
    else $error("empty result with non-zero occupancy");

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the maximum-priority queue
// Drives enqueue and dequeue items into max_priority_queue_array, keeps a
// shadow copy of the stored entries to predict every result item, and
// compares each result field by field under varying sender and receiver
// idling.
// ----------------------------------------------------------------------------
import mpqa_pkg::*;

// Shadow of the queue contents together with the results still owed.
class pq_shadow;
  logic [KEY_W-1:0] key_row[CAPACITY];
  logic [TAG_W-1:0] name_row[CAPACITY];
  logic [TAG_W-1:0] ident_row[CAPACITY];
  int unsigned      fill;
  int unsigned      peak;
  int unsigned      fails;
  int unsigned      n_enq, n_full, n_deq, n_empty;

  typedef struct packed {
    status_t          status;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] name;
    logic [TAG_W-1:0] ident;
    logic [OCC_W-1:0] occ;
  } reply_t;

  reply_t due_replies[$];

  function new();
    fill  = 0;
    peak  = 0;
    fails = 0;
    n_enq = 0;
    n_full = 0;
    n_deq = 0;
    n_empty = 0;
  endfunction

  // Applies one accepted operation to the shadow and queues its result.
  function void apply_op(logic func, logic [KEY_W-1:0] key,
                         logic [TAG_W-1:0] name, logic [TAG_W-1:0] ident);
    reply_t      r;
    int unsigned top;
    r = '0;
    if (func == FUNC_ENQ) begin
      if (fill == CAPACITY) begin
        r.status = STAT_FULL;
      end else begin
        key_row[fill]   = key;
        name_row[fill]  = name;
        ident_row[fill] = ident;
        fill++;
        r.status = STAT_ENQUEUED;
      end
    end else if (fill == 0) begin
      r.status = STAT_EMPTY;
    end else begin
      // Strictly greater, so the earliest of equal keys stays the winner.
      top = 0;
      for (int i = 1; i < fill; i++)
        if (key_row[i] > key_row[top]) top = i;
      r.status = STAT_DEQUEUED;
      r.key    = key_row[top];
      r.name   = name_row[top];
      r.ident  = ident_row[top];
      for (int i = top; i + 1 < fill; i++) begin
        key_row[i]   = key_row[i + 1];
        name_row[i]  = name_row[i + 1];
        ident_row[i] = ident_row[i + 1];
      end
      fill--;
    end
    r.occ = OCC_W'(fill);
    if (fill > peak) peak = fill;
    due_replies.push_back(r);
  endfunction

  // Compares one accepted result with the oldest outstanding one.
  function void match_reply(logic [1:0] status, logic [KEY_W-1:0] key,
                            logic [TAG_W-1:0] name, logic [TAG_W-1:0] ident,
                            logic [OCC_W-1:0] occ);
    reply_t exp;
    if (due_replies.size() == 0) begin
      $error("result item with none outstanding: status %0d key %0h", status, key);
      fails++;
      return;
    end
    exp = due_replies.pop_front();
    if (status !== exp.status) begin
      $error("status: expected %0d, got %0d", exp.status, status);
      fails++;
    end
    if (key !== exp.key) begin
      $error("out_key: expected %0h, got %0h", exp.key, key);
      fails++;
    end
    if (name !== exp.name) begin
      $error("out_name_tag: expected %0h, got %0h", exp.name, name);
      fails++;
    end
    if (ident !== exp.ident) begin
      $error("out_ident_tag: expected %0h, got %0h", exp.ident, ident);
      fails++;
    end
    if (occ !== exp.occ) begin
      $error("out_occupancy: expected %0d, got %0d", exp.occ, occ);
      fails++;
    end
    case (exp.status)
      STAT_ENQUEUED: n_enq++;
      STAT_FULL:     n_full++;
      STAT_DEQUEUED: n_deq++;
      default:       n_empty++;
    endcase
  endfunction

  function int unsigned waiting();
    return due_replies.size();
  endfunction
endclass

module tb_top;

  // Random items per idling phase; four phases give roughly 1750 items.
  localparam int PHASE_ITEMS = 435;
  // Length of the deliberate receiver hold-off, in clock cycles.
  localparam int HOLD_CYCLES = 60;
  // Cycles without any handshake before the run is declared hung. The
  // slowest legitimate gap is the hold-off above plus a dequeue scan.
  localparam int STALL_LIMIT = 1000;
  // Quiet cycles after the last result, to catch any stray result item.
  localparam int TAIL_CYCLES = CAPACITY + 8;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic             in_func;
  logic [KEY_W-1:0] in_entry_key;
  logic [TAG_W-1:0] in_name_tag;
  logic [TAG_W-1:0] in_ident_tag;
  logic             out_valid;
  logic             out_stall;
  logic [1:0]       out_status;
  logic [KEY_W-1:0] out_key;
  logic [TAG_W-1:0] out_name_tag;
  logic [TAG_W-1:0] out_ident_tag;
  logic [OCC_W-1:0] out_occupancy;

  pq_shadow    sb;
  int          send_gap_pct;
  int          stall_pct;
  logic        hold_req;
  int unsigned idle_cycles;
  int unsigned items_in;

  max_priority_queue_array DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_entry_key  (in_entry_key),
    .in_name_tag   (in_name_tag),
    .in_ident_tag  (in_ident_tag),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_key       (out_key),
    .out_name_tag  (out_name_tag),
    .out_ident_tag (out_ident_tag),
    .out_occupancy (out_occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Tags are mostly random, with the all-zero and all-one patterns mixed in
  // so that the extremes turn up regularly.
  function automatic logic [TAG_W-1:0] pick_tag();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom();
  endfunction

  // Offers one item. Any idle gap is decided before valid is raised, so
  // valid never follows the stall; the payload then holds until the item
  // is taken at a rising edge with in_stall low.
  task automatic offer_op(input logic func, input logic [KEY_W-1:0] key,
                          input logic [TAG_W-1:0] name, input logic [TAG_W-1:0] ident);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_func      = func;
    in_entry_key = key;
    in_name_tag  = name;
    in_ident_tag = ident;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // The sender falls silent until every outstanding result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.waiting() != 0) @(negedge clk);
  endtask

  // Receiver: stalls at random according to the current phase. When a
  // hold-off is requested it keeps out_stall high for a long stretch, so
  // the output register and the block both fill and in_stall rises.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req  = 1'b0;
        out_stall = 1'b0;
      end else begin
        out_stall = ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Both channels are sampled at the rising edge. Each accepted item is fed
  // to the shadow queue, each accepted result is checked against it, and a
  // watchdog ends the run if no handshake happens for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.apply_op(in_func, in_entry_key, in_name_tag, in_ident_tag);
        items_in++;
      end
      if (out_valid && !out_stall)
        sb.match_reply(out_status, out_key, out_name_tag, out_ident_tag, out_occupancy);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
          $display("max_priority_queue_array: mismatch");
          $finish;
        end
      end
    end
  end

  initial begin
    logic             func;
    logic [KEY_W-1:0] key;
    int unsigned      enq_pct;
    int unsigned      r;

    sb            = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_func       = FUNC_ENQ;
    in_entry_key  = '0;
    in_name_tag   = '0;
    in_ident_tag  = '0;
    hold_req      = 1'b0;
    send_gap_pct  = 0;
    stall_pct     = 0;
    idle_cycles   = 0;
    items_in      = 0;
    enq_pct       = 50;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. A dequeue on the empty queue comes first, carrying
    // junk key and tags that must be ignored. The queue is then filled to
    // capacity with extreme keys and tags and with duplicated keys, one
    // more enqueue is dropped as full, and everything is dequeued again so
    // that ties resolve to the earlier entry. A further dequeue meets the
    // empty queue once more, and a single enqueue and dequeue close the part.
    offer_op(FUNC_DEQ, 8'hff, '1, '1);
    offer_op(FUNC_ENQ, 8'h00, '0, '0);
    offer_op(FUNC_ENQ, 8'hff, '1, '1);
    offer_op(FUNC_ENQ, 8'h07, 32'ha5a5a5a5, 32'h5a5a5a5a);
    offer_op(FUNC_ENQ, 8'hff, 32'h12345678, 32'h87654321);
    offer_op(FUNC_ENQ, 8'h07, 32'h0f0f0f0f, 32'hf0f0f0f0);
    offer_op(FUNC_ENQ, 8'h80, 32'h80000000, 32'h00000001);
    offer_op(FUNC_ENQ, 8'h01, 32'h00000001, 32'h80000000);
    offer_op(FUNC_ENQ, 8'h00, 32'hdeadbeef, 32'hcafef00d);
    offer_op(FUNC_ENQ, 8'hc8, 32'h11111111, 32'h22222222);
    repeat (8) offer_op(FUNC_DEQ, KEY_W'($urandom()), $urandom(), $urandom());
    offer_op(FUNC_DEQ, 8'h00, '0, '0);
    offer_op(FUNC_ENQ, 8'h2a, 32'h33333333, 32'h44444444);
    offer_op(FUNC_DEQ, 8'h55, '1, '0);
    drain_results();

    // Random part in four idling phases: none, sender gaps, receiver
    // stalls, then a light mix of both. The enqueue share is redrawn every
    // forty items so that the queue swings between empty and full, and
    // keys are drawn mostly from a narrow range to produce plenty of ties.
    for (int phase = 0; phase < 4; phase++) begin
      send_gap_pct = (phase == 1) ? 45 : (phase == 3) ? 9 : 0;
      stall_pct    = (phase == 2) ? 45 : (phase == 3) ? 9 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) begin
          case ($urandom_range(0, 2))
            0:       enq_pct = 20;
            1:       enq_pct = 50;
            default: enq_pct = 80;
          endcase
        end
        // A long receiver hold-off while the sender keeps offering.
        if (phase == 0 && n == 100) hold_req = 1'b1;
        // A sender pause until every outstanding result is back.
        if (phase == 1 && n == 200) drain_results();
        func = ($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
        r = $urandom_range(0, 9);
        if (r < 5)       key = KEY_W'($urandom_range(0, 3));
        else if (r == 5) key = 8'h00;
        else if (r == 6) key = 8'hff;
        else             key = KEY_W'($urandom());
        offer_op(func, key, pick_tag(), pick_tag());
      end
      drain_results();
    end

    // Every result is in; give the block time to show any stray result.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d items: %0d enqueued, %0d dropped as full, %0d dequeued,",
             items_in, sb.n_enq, sb.n_full, sb.n_deq);
    $display("%0d dequeues on an empty queue; occupancy reached %0d of %0d.",
             sb.n_empty, sb.peak, CAPACITY);
    if (sb.fails == 0) begin
      $display("max_priority_queue_array: match");
    end else begin
      $display("max_priority_queue_array: mismatch");
    end
    $finish;
  end

endmodule

FILE: max_priority_queue_array.f
design/mpqa_pkg.sv
design/mpqa_cell.sv
design/mpqa_ctrl.sv
design/max_priority_queue_array.sv
test/tb_top.sv
